// ===== rtl/rmrs_pkg.sv =====
// shared types, constants and codes for the row scan driver
package rmrs_pkg;

	// panel geometry
	localparam int COLUMNS = 64;
	localparam int ROWS    = 32;
	localparam int PLANES  = 4;

	// frame store geometry: four planes of 1024 words
	localparam int PIXEL_W     = 6;
	localparam int INDEX_W     = 10;
	localparam int PLANE_W     = 2;
	localparam int ROW_W       = 4;
	localparam int COL_W       = 6;
	localparam int STORE_AW    = PLANE_W + INDEX_W;
	localparam int STORE_DEPTH = 1 << STORE_AW;

	// scan limits, clamped to what the counters and the store can hold
	localparam int ROW_HALF    = ROWS / 2;
	localparam int ROW_LIMIT   = (ROW_HALF < 1) ? 1 : ((ROW_HALF > 16) ? 16 : ROW_HALF);
	localparam int PLANE_LIMIT = (PLANES > 4) ? 4 : PLANES;
	localparam int COL_COUNT   = (COLUMNS > 64) ? 64 : COLUMNS;

	localparam logic [ROW_W-1:0]   ROW_WRAP   = ROW_W'(ROW_LIMIT - 1);
	localparam logic [PLANE_W-1:0] PLANE_WRAP = PLANE_W'(PLANE_LIMIT - 1);
	localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(COL_COUNT - 1);

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic               op;
		logic [PLANE_W-1:0] wr_plane;
		logic [INDEX_W-1:0] wr_index;
		logic [PIXEL_W-1:0] wr_pixel;
	} item_t;

	typedef struct packed {
		logic               latch_pulse;
		logic [ROW_W-1:0]   latch_row;
		logic [PIXEL_W-1:0] pixel_bits;
		logic [COL_W-1:0]   column;
		logic [PLANE_W-1:0] plane_now;
		logic               last;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_SHIFT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic store_wr;
		logic tick_load;
		logic shift;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic col_last;
	} status_t;

endpackage

// ===== rtl/rmrs_ram.sv =====
// generic simple dual port ram with registered read
module rmrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/rmrs_ctrl.sv =====
// scan controller state machine
module rmrs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             op,
	input  rmrs_pkg::status_t status,
	output logic             busy,
	output rmrs_pkg::cmd_t   cmd
);
	import rmrs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && op == OP_TICK) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (status.col_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy          = 1'b0;
		cmd.store_wr  = 1'b0;
		cmd.tick_load = 1'b0;
		cmd.shift     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.store_wr  = start && op == OP_WRITE;
				cmd.tick_load = start && op == OP_TICK;
			end
			ST_SHIFT: begin
				busy      = 1'b1;
				cmd.shift = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

	ctrl_leave_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		busy && status.col_last |=> !busy)
		else $error("controller stayed busy after last column");

	ctrl_tick_starts_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_load |=> cmd.shift)
		else $error("tick transfer did not start a shift");

	ctrl_no_write_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.store_wr && cmd.shift))
		else $error("store write during a shift");

endmodule

// ===== rtl/rmrs_dp.sv =====
// scan datapath: row and plane counters, column counter, frame store, result stage
module rmrs_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rmrs_pkg::item_t   item,
	input  rmrs_pkg::cmd_t    cmd,
	output rmrs_pkg::status_t status,
	output logic              result_valid,
	output rmrs_pkg::result_t result
);
	import rmrs_pkg::*;

	logic [ROW_W-1:0]   row_q;
	logic [PLANE_W-1:0] plane_q;
	logic [ROW_W-1:0]   latched_q;
	logic [COL_W-1:0]   col_q;

	logic               valid_s1;
	logic               first_s1;
	logic               last_s1;
	logic [COL_W-1:0]   col_s1;

	logic [INDEX_W-1:0]  rd_index;
	logic [STORE_AW-1:0] rd_addr;
	logic [STORE_AW-1:0] wr_addr;
	logic [PIXEL_W-1:0]  rd_data;
	logic [15:0]         index_sum;

	assign status.col_last = (col_q == COL_LAST);

	// read index wraps within one plane
	assign index_sum = 16'(row_q) * 16'(COLUMNS) + 16'(col_q);
	assign rd_index  = index_sum[INDEX_W-1:0];
	assign rd_addr   = {plane_q, rd_index};
	assign wr_addr   = {item.wr_plane, item.wr_index};

	// row and plane advance when a tick is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			plane_q   <= '0;
			latched_q <= '0;
			col_q     <= '0;
		end else if (cmd.tick_load) begin
			latched_q <= row_q;
			col_q     <= '0;
			if (row_q >= ROW_WRAP) begin
				row_q <= '0;
				if (plane_q >= PLANE_WRAP) begin
					plane_q <= '0;
				end else begin
					plane_q <= plane_q + 1'b1;
				end
			end else begin
				row_q <= row_q + 1'b1;
			end
		end else if (cmd.shift) begin
			col_q <= col_q + 1'b1;
		end
	end

	rmrs_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.store_wr),
		.wr_addr (wr_addr),
		.wr_data (item.wr_pixel),
		.rd_en   (cmd.shift),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// registered together with the store read, so the valid flag lines up with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.shift;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (col_q == '0);
		last_s1  <= status.col_last;
		col_s1   <= col_q;
	end

	assign result_valid       = valid_s1;
	assign result.latch_pulse = first_s1;
	assign result.latch_row   = latched_q;
	assign result.pixel_bits  = rd_data;
	assign result.column      = col_s1;
	assign result.plane_now   = plane_q;
	assign result.last        = last_s1;

	dp_first_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_load |-> ##2 (valid_s1 && first_s1))
		else $error("first pixel word missing after tick");

	dp_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |=> !valid_s1)
		else $error("pixel word after the last column");

	dp_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_WRAP)
		else $error("row counter out of range");

endmodule

// ===== rtl/rgb_matrix_row_scan_driver_unit.sv =====
// top level of the rgb matrix row scan driver
//
// channel   signals                     direction  transfer when
// command   start, busy, item           in         start high and busy low
// result    result_valid, result        out        result_valid high
//
// a write transfer stores one pixel word, busy stays low
// a tick transfer latches the row and steps the counters, then the shift state
// does one store read per column on the single frame store read port
// results follow the reads in the next cycle (registered read), one word a cycle
// the receiver cannot stall; reset clears counters and control, not the store
module rgb_matrix_row_scan_driver_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rmrs_pkg::item_t   item,
	output logic              result_valid,
	output rmrs_pkg::result_t result
);
	import rmrs_pkg::*;

	// controller to datapath commands and status
	cmd_t    cmd;
	status_t status;

	// sequences writes and the column sweep of a tick
	rmrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.op),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// counters, frame store and the result stage
	rmrs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== tb/rgb_matrix_row_scan_driver_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench for the row scan driver: directed table, then random writes and refresh ticks
module rgb_matrix_row_scan_driver_unit_tb;
	import rmrs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 23;
	localparam int RAND_ITEMS  = 200;
	localparam int MIN_TICKS   = 80;
	localparam int DIR_ROWS    = 14;

	// one row of the directed table; reps repeats the row, first_word pins the
	// first shifted word of a tick when pinned is set
	typedef struct {
		logic               op;
		logic [PLANE_W-1:0] plane;
		logic [INDEX_W-1:0] index;
		logic [PIXEL_W-1:0] pixel;
		int                 reps;
		bit                 pinned;
		result_t            first_word;
	} dir_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    result_valid;
	result_t result;

	// typed first word travels with the tick transfer it belongs to
	bit      pin_en;
	result_t pin_word;

	// predictor: its own copy of the frame store and the scan counters
	logic [PIXEL_W-1:0] frame_mem [STORE_DEPTH];
	logic [ROW_W-1:0]   scan_row;
	logic [PLANE_W-1:0] scan_plane;
	result_t            want_words [$];
	int                 bad_count = 0;
	int                 cycle_count = 0;

	// stimulus side: which store words were written, and where the next tick
	// will read, so that no tick ever reads a word nobody wrote
	bit                 written [STORE_DEPTH];
	logic [ROW_W-1:0]   plan_row;
	logic [PLANE_W-1:0] plan_plane;
	bit                 idle_ok;
	int                 tick_count = 0;
	dir_row_t           dir_tab [DIR_ROWS];

	rgb_matrix_row_scan_driver_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// row counter wraps at the half height, the plane steps on each row wrap
	task automatic advance_scan(inout logic [ROW_W-1:0] r, inout logic [PLANE_W-1:0] p);
		if (int'(r) + 1 >= ROW_LIMIT) begin
			r = '0;
			p = (int'(p) + 1 >= PLANE_LIMIT) ? '0 : p + 1'b1;
		end else begin
			r = r + 1'b1;
		end
	endtask

	// expected words of one tick: latch the old row, step, then read the new row
	task automatic shift_row(input bit pinned, input result_t typed);
		logic [ROW_W-1:0]   latched;
		logic [INDEX_W-1:0] idx;
		result_t            w;
		latched = scan_row;
		advance_scan(scan_row, scan_plane);
		for (int x = 0; x < COL_COUNT; x++) begin
			// read index wraps inside the plane's 1024 words
			idx = INDEX_W'(int'(scan_row) * COLUMNS + x);
			w.latch_pulse = (x == 0);
			w.latch_row   = latched;
			w.pixel_bits  = frame_mem[{scan_plane, idx}];
			w.column      = COL_W'(x);
			w.plane_now   = scan_plane;
			w.last        = (x == COL_COUNT - 1);
			if (x == 0 && pinned)
				w = typed;
			want_words.push_back(w);
		end
	endtask

	task automatic cmp_field(input string name, input logic [7:0] e, input logic [7:0] a);
		if (e !== a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			bad_count++;
		end
	endtask

	task automatic check_word(input result_t got);
		result_t e;
		if (want_words.size() == 0) begin
			$error("result transfer with nothing expected: %p", got);
			bad_count++;
		end else begin
			e = want_words.pop_front();
			cmp_field("latch_pulse", 8'(e.latch_pulse), 8'(got.latch_pulse));
			cmp_field("latch_row", 8'(e.latch_row), 8'(got.latch_row));
			cmp_field("pixel_bits", 8'(e.pixel_bits), 8'(got.pixel_bits));
			cmp_field("column", 8'(e.column), 8'(got.column));
			cmp_field("plane_now", 8'(e.plane_now), 8'(got.plane_now));
			cmp_field("last", 8'(e.last), 8'(got.last));
		end
	endtask

	// monitor: a command transfer feeds the predictor before the same edge's
	// result is checked, so ordering within the edge does not matter
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				if (item.op == OP_WRITE)
					frame_mem[{item.wr_plane, item.wr_index}] = item.wr_pixel;
				else
					shift_row(pin_en, pin_word);
			end
			if (result_valid)
				check_word(result);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rgb_matrix_row_scan_driver_unit: mismatch");
			$finish;
		end
	end

	// drive one command at the falling edge and hold it until the transfer;
	// an optional idle gap first, short mostly and now and then past a whole tick
	task automatic send_item(input item_t it, input bit pinned, input result_t typed);
		int gap;
		if (idle_ok && $urandom_range(99) < IDLE_PCT) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(70, 1) : $urandom_range(3, 1);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start    <= 1'b1;
		item     <= it;
		pin_en   <= pinned;
		pin_word <= typed;
		if (it.op == OP_WRITE)
			written[{it.wr_plane, it.wr_index}] = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic send_write(input logic [PLANE_W-1:0] p, input logic [INDEX_W-1:0] idx,
			input logic [PIXEL_W-1:0] px);
		item_t it;
		it.op       = OP_WRITE;
		it.wr_plane = p;
		it.wr_index = idx;
		it.wr_pixel = px;
		send_item(it, 1'b0, '0);
	endtask

	// a tick, preceded by writes of random content to any word of the target
	// row that was never written; unused fields of the tick carry noise
	task automatic issue_tick(input bit pinned, input result_t typed);
		logic [INDEX_W-1:0] idx;
		item_t              it;
		advance_scan(plan_row, plan_plane);
		for (int x = 0; x < COL_COUNT; x++) begin
			idx = INDEX_W'(int'(plan_row) * COLUMNS + x);
			if (!written[{plan_plane, idx}])
				send_write(plan_plane, idx, PIXEL_W'($urandom));
		end
		it.op       = OP_TICK;
		it.wr_plane = PLANE_W'($urandom);
		it.wr_index = INDEX_W'($urandom);
		it.wr_pixel = PIXEL_W'($urandom);
		send_item(it, pinned, typed);
		tick_count++;
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		pin_en     = 1'b0;
		pin_word   = '0;
		scan_row   = '0;
		scan_plane = '0;
		plan_row   = '0;
		plan_plane = '0;
		idle_ok    = 1'b1;

		// directed part: field extremes, both operations, the first tick after
		// reset, a pass over rows 1 to 15 of plane 0 and the row wrap into plane 1
		dir_tab = '{
			'{OP_WRITE, 2'd0, 10'd0,    6'h00, 1,  1'b0, '0},
			'{OP_WRITE, 2'd3, 10'd1023, 6'h3F, 1,  1'b0, '0},
			'{OP_WRITE, 2'd1, 10'd512,  6'h2A, 1,  1'b0, '0},
			'{OP_WRITE, 2'd2, 10'd341,  6'h15, 1,  1'b0, '0},
			'{OP_WRITE, 2'd0, 10'd64,   6'h3F, 1,  1'b0, '0},
			'{OP_WRITE, 2'd0, 10'd127,  6'h01, 1,  1'b0, '0},
			// first tick after reset latches row 0 and shifts row 1 of plane 0
			'{OP_TICK,  2'd0, 10'd0,    6'h00, 1,  1'b1,
				result_t'{1'b1, 4'd0, 6'h3F, 6'd0, 2'd0, 1'b0}},
			'{OP_TICK,  2'd0, 10'd0,    6'h00, 13, 1'b0, '0},
			'{OP_WRITE, 2'd0, 10'd1023, 6'h2A, 1,  1'b0, '0},
			'{OP_TICK,  2'd0, 10'd0,    6'h00, 1,  1'b0, '0},
			'{OP_WRITE, 2'd1, 10'd0,    6'h3C, 1,  1'b0, '0},
			// top row latched, row counter wraps and the plane steps to 1
			'{OP_TICK,  2'd0, 10'd0,    6'h00, 1,  1'b1,
				result_t'{1'b1, 4'd15, 6'h3C, 6'd0, 2'd1, 1'b0}},
			'{OP_WRITE, 2'd2, 10'd5,    6'h3F, 1,  1'b0, '0},
			'{OP_TICK,  2'd0, 10'd0,    6'h00, 1,  1'b0, '0}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			repeat (dir_tab[i].reps) begin
				if (dir_tab[i].op == OP_TICK)
					issue_tick(dir_tab[i].pinned, dir_tab[i].first_word);
				else
					send_write(dir_tab[i].plane, dir_tab[i].index, dir_tab[i].pixel);
			end
		end

		// random part: writes anywhere, ticks until the planes have wrapped
		// around; one stretch runs with no idle gaps at all
		for (int n = 0; n < RAND_ITEMS || tick_count < MIN_TICKS; n++) begin
			idle_ok = !(n >= 60 && n < 120);
			if ($urandom_range(99) < 35)
				issue_tick(1'b0, '0);
			else
				send_write(PLANE_W'($urandom), INDEX_W'($urandom), PIXEL_W'($urandom));
		end

		@(negedge clk);
		start <= 1'b0;

		// drain, then give a stray word a full row's time to show up
		while (want_words.size() != 0)
			@(posedge clk);
		repeat (COL_COUNT + 8) @(posedge clk);

		if (bad_count == 0)
			$display("rgb_matrix_row_scan_driver_unit: match");
		else
			$display("rgb_matrix_row_scan_driver_unit: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rmrs_pkg.sv
rtl/rmrs_ram.sv
rtl/rmrs_ctrl.sv
rtl/rmrs_dp.sv
rtl/rgb_matrix_row_scan_driver_unit.sv
tb/rgb_matrix_row_scan_driver_unit_tb.sv
